[rtl/plc_pkg.sv]
// Package for the piecewise-linear calibration block.
// Holds table sizes, register indexes, reset values and pipeline payload types.
// No dependencies.
package plc_pkg;

   // Calibration table geometry.
   localparam int MaxPoints   = 16;
   localparam int IdxW        = $clog2(MaxPoints);
   localparam int CountW      = 5;
   localparam int SampleW     = 8;
   localparam int ValueW      = 16;
   localparam int RegW        = 64;
   localparam int NumW        = ValueW + SampleW;

   // Pipelined divider layout: quotient bits resolved per pipeline stage.
   localparam int DivBitsPerStage = 4;
   localparam int DivStages       = NumW / DivBitsPerStage;

   // Register indexes of the configuration port.
   localparam int CsrIdxW = 3;
   typedef enum logic [CsrIdxW-1:0] {
      REG_POINT_COUNT = 3'd0,
      REG_BP_LOW      = 3'd1,
      REG_BP_HIGH     = 3'd2,
      REG_TGT_0_3     = 3'd3,
      REG_TGT_4_7     = 3'd4,
      REG_TGT_8_11    = 3'd5,
      REG_TGT_12_15   = 3'd6
   } csr_index_type;

   // Reset contents of the configuration registers.
   localparam logic [CountW-1:0] RstPointCount = 5'd11;
   localparam logic [RegW-1:0]   RstBpLow      = 64'hCABA9F8060402300;
   localparam logic [RegW-1:0]   RstBpHigh     = 64'h0000000000FFE7D9;
   localparam logic [RegW-1:0]   RstTgt03      = 64'h0012000C00060002;
   localparam logic [RegW-1:0]   RstTgt47      = 64'h0060004800300018;
   localparam logic [RegW-1:0]   RstTgt811     = 64'h000000A800900078;
   localparam logic [RegW-1:0]   RstTgt1215    = 64'h0000000000000000;

   // Payload carried through the divider stages.
   typedef struct packed {
      logic [SampleW-1:0] rem;   // partial remainder
      logic [NumW-1:0]    num;   // dividend bits, quotient shifts in low
      logic [SampleW-1:0] den;   // segment width
      logic               neg;   // slope is negative
      logic [ValueW-1:0]  lo;    // target at segment start
   } div_type;

endpackage

[rtl/plc_if.sv]
// Handshake interfaces for the sample and result channels.
// Depends on plc_pkg for field widths.
interface plc_req_if import plc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SampleW-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface plc_rsp_if import plc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ValueW-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

[rtl/plc_div_stage.sv]
// One stage of the pipelined restoring divider.
// Depends on plc_pkg for the divider payload type.
module plc_div_stage import plc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  logic    valid_in,
   input  div_type data_in,
   output logic    valid_out,
   output div_type data_out
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in_next;

   // Resolve DivBitsPerStage quotient bits, one restoring step each.
   always_comb begin
      logic [SampleW:0] trial;
      data_in_next = data_in;
      for (int k = 0; k < DivBitsPerStage; k++) begin
         trial = {data_in_next.rem, data_in_next.num[NumW-1]};
         data_in_next.num = {data_in_next.num[NumW-2:0], 1'b0};
         if (trial >= {1'b0, data_in_next.den}) begin
            trial = trial - {1'b0, data_in_next.den};
            data_in_next.num[0] = 1'b1;
         end
         data_in_next.rem = trial[SampleW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

[rtl/piecewise_linear_calibration.sv]
// Piecewise-linear calibration: maps an 8-bit sample through up to 16 points.
// One item per cycle is sustained while no result waits at the output.
// Stages: segment search, segment select, multiply, six divider stages, output.
// The whole pipeline holds while a result waits at the output.
// Synchronous reset clears valid bits and loads the default calibration table.
module piecewise_linear_calibration import plc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   plc_req_if.sink             req_chan,
   plc_rsp_if.source           rsp_chan,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [RegW-1:0]     csr_wdata
);

   // Configuration registers.
   logic [CountW-1:0] count_ff;
   logic [RegW-1:0]   bp_low_ff, bp_high_ff;
   logic [RegW-1:0]   tgt03_ff, tgt47_ff, tgt811_ff, tgt1215_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= RstPointCount;
         bp_low_ff  <= RstBpLow;
         bp_high_ff <= RstBpHigh;
         tgt03_ff   <= RstTgt03;
         tgt47_ff   <= RstTgt47;
         tgt811_ff  <= RstTgt811;
         tgt1215_ff <= RstTgt1215;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_POINT_COUNT: count_ff   <= csr_wdata[CountW-1:0];
            REG_BP_LOW:      bp_low_ff  <= csr_wdata;
            REG_BP_HIGH:     bp_high_ff <= csr_wdata;
            REG_TGT_0_3:     tgt03_ff   <= csr_wdata;
            REG_TGT_4_7:     tgt47_ff   <= csr_wdata;
            REG_TGT_8_11:    tgt811_ff  <= csr_wdata;
            REG_TGT_12_15:   tgt1215_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Unpack the table and derive the per-segment static terms.
   logic [SampleW-1:0] bp  [MaxPoints];
   logic [ValueW-1:0]  tgt [MaxPoints];
   logic [SampleW-1:0] prev [MaxPoints];
   logic [MaxPoints-1:0] stop, in_use;
   logic [CountW-1:0]  n_eff;
   logic [IdxW-1:0]    last_idx;

   always_comb begin
      logic [2*RegW-1:0] bpw;
      logic [4*RegW-1:0] tw;
      bpw = {bp_high_ff, bp_low_ff};
      tw  = {tgt1215_ff, tgt811_ff, tgt47_ff, tgt03_ff};
      if (count_ff < CountW'(2)) n_eff = CountW'(2);
      else if (count_ff > CountW'(MaxPoints)) n_eff = CountW'(MaxPoints);
      else n_eff = count_ff;
      last_idx = IdxW'(n_eff - CountW'(1));
      for (int i = 0; i < MaxPoints; i++) begin
         bp[i]  = bpw[i*SampleW +: SampleW];
         tgt[i] = tw[i*ValueW +: ValueW];
      end
      for (int i = 0; i < MaxPoints; i++) begin
         prev[i]   = (i <= 1) ? '0 : bp[(i > 0) ? i-1 : 0];
         stop[i]   = (i >= 1) && (bp[i] <= prev[i]);
         in_use[i] = (i >= 1) && (CountW'(i) < n_eff);
      end
   end

   logic adv;
   logic rsp_valid_ff;
   logic [ValueW-1:0] rsp_value_ff;

   // The pipeline moves whenever the output register can take a result.
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Stage 1: first segment that stops or covers the sample.
   logic               s1_valid_ff;
   logic [SampleW-1:0] s1_sample_ff;
   logic [IdxW-1:0]    s1_sel_ff, s1_sel_in;
   logic               s1_found_ff, s1_found_in;

   always_comb begin
      s1_sel_in   = '0;
      s1_found_in = 1'b0;
      for (int i = MaxPoints-1; i >= 1; i--) begin
         if (in_use[i] && (stop[i] || req_chan.sample <= bp[i])) begin
            s1_sel_in   = IdxW'(i);
            s1_found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sample_ff <= req_chan.sample;
         s1_sel_ff    <= s1_sel_in;
         s1_found_ff  <= s1_found_in;
      end
   end

   // Stage 2: segment endpoints, slope magnitude and offsets.
   logic               s2_valid_ff;
   logic [ValueW-1:0]  s2_lo_ff, s2_lo_in;
   logic [ValueW-1:0]  s2_mag_ff, s2_mag_in;
   logic               s2_neg_ff, s2_neg_in;
   logic [SampleW-1:0] s2_dx_ff, s2_dx_in;
   logic [SampleW-1:0] s2_den_ff, s2_den_in;

   always_comb begin
      logic [IdxW-1:0]    lo_idx;
      logic [ValueW-1:0]  t_lo, t_hi;
      lo_idx    = s1_sel_ff - IdxW'(1);
      t_lo      = tgt[lo_idx];
      t_hi      = tgt[s1_sel_ff];
      s2_lo_in  = s1_found_ff ? t_lo : '0;
      s2_mag_in = '0;
      s2_neg_in = 1'b0;
      s2_dx_in  = '0;
      s2_den_in = SampleW'(1);
      // Interpolate only inside a rising segment.
      if (s1_found_ff && !stop[s1_sel_ff]) begin
         s2_neg_in = t_hi < t_lo;
         s2_mag_in = s2_neg_in ? t_lo - t_hi : t_hi - t_lo;
         s2_dx_in  = s1_sample_ff - prev[s1_sel_ff];
         s2_den_in = bp[s1_sel_ff] - prev[s1_sel_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_lo_ff  <= s2_lo_in;
         s2_mag_ff <= s2_mag_in;
         s2_neg_ff <= s2_neg_in;
         s2_dx_ff  <= s2_dx_in;
         s2_den_ff <= s2_den_in;
      end
   end

   // Stage 3: numerator magnitude.
   logic    s3_valid_ff;
   div_type s3_data_ff, s3_data_in;

   always_comb begin
      s3_data_in.rem = '0;
      s3_data_in.num = NumW'(s2_mag_ff) * NumW'(s2_dx_ff);
      s3_data_in.den = s2_den_ff;
      s3_data_in.neg = s2_neg_ff;
      s3_data_in.lo  = s2_lo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_data_ff <= s3_data_in;
      end
   end

   // Divider chain.
   logic    dv_valid [DivStages+1];
   div_type dv_data  [DivStages+1];

   assign dv_valid[0] = s3_valid_ff;
   assign dv_data[0]  = s3_data_ff;

   for (genvar g = 0; g < DivStages; g++) begin : g_div
      plc_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .valid_in  (dv_valid[g]),
         .data_in   (dv_data[g]),
         .valid_out (dv_valid[g+1]),
         .data_out  (dv_data[g+1])
      );
   end

   // Output stage: apply the sign, add the base, fall back on the last target.
   logic [ValueW-1:0] rsp_value_in;

   always_comb begin
      logic [ValueW-1:0] q, sum;
      q   = dv_data[DivStages].num[ValueW-1:0];
      sum = dv_data[DivStages].neg ? dv_data[DivStages].lo - q
                                   : dv_data[DivStages].lo + q;
      rsp_value_in = (sum == '0) ? tgt[last_idx] : sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid[DivStages];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = rsp_value_ff;

endmodule

[rtl/plc_checker.sv]
// Port-level checks for the piecewise-linear calibration block.
// Depends on plc_pkg and the channel interfaces; bound to the top level.
module plc_checker import plc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ValueW-1:0] rsp_value
);

   // A pending result is held until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result dropped or changed while stalled");

   // Input is stalled whenever a result waits, and free while the output is empty.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while output stalled");

   a_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // Nothing appears right after reset.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule

bind piecewise_linear_calibration plc_checker u_plc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_value (rsp_chan.value)
);

[dv/piecewise_linear_calibration_tb.sv]
// Self-checking testbench for the piecewise-linear calibration block.
// Drives samples through plc_req_if, checks values on plc_rsp_if against a local predictor.
// Depends on plc_pkg, plc_if.sv and the piecewise_linear_calibration RTL.
module piecewise_linear_calibration_tb;
   import plc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = REG_POINT_COUNT;
   logic [RegW-1:0] csr_wdata = '0;

   plc_req_if req_chan ();
   plc_rsp_if rsp_chan ();

   piecewise_linear_calibration dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Local copy of the calibration table.
   logic [CountW-1:0] cal_count;
   logic [RegW-1:0] cal_bp [2];
   logic [RegW-1:0] cal_tgt [4];

   logic [SampleW-1:0] pending_samples [$];
   logic [ValueW-1:0] expected_values [$];
   int mismatches = 0;
   int checked = 0;
   int sent = 0;
   bit rsp_hold_long = 1'b0;
   bit send_paused = 1'b0;

   function automatic int bp_of(int i);
      return int'(cal_bp[i[3:3]][(i % 8) * 8 +: 8]);
   endfunction

   function automatic longint tgt_of(int i);
      return longint'(cal_tgt[i / 4][(i % 4) * 16 +: 16]);
   endfunction

   // Interpolated value for one sample under the current table.
   function automatic logic [ValueW-1:0] calibrate(logic [SampleW-1:0] s);
      int n;
      int prev;
      int bp;
      longint res;
      longint lo;
      n = int'(cal_count);
      prev = 0;
      res = 0;
      if (n < 2) n = 2;
      if (n > MaxPoints) n = MaxPoints;
      for (int i = 1; i < n; i++) begin
         bp = bp_of(i);
         if (bp <= prev) begin
            res = tgt_of(i - 1);
            break;
         end
         if (int'(s) <= bp) begin
            lo = tgt_of(i - 1);
            res = lo + ((tgt_of(i) - lo) * longint'(int'(s) - prev)) / longint'(bp - prev);
            break;
         end
         prev = bp;
      end
      if (res[15:0] == 16'd0) res = tgt_of(n - 1);
      return res[15:0];
   endfunction

   task automatic write_reg(csr_index_type idx, logic [RegW-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_POINT_COUNT: cal_count = data[CountW-1:0];
         REG_BP_LOW:      cal_bp[0] = data;
         REG_BP_HIGH:     cal_bp[1] = data;
         REG_TGT_0_3:     cal_tgt[0] = data;
         REG_TGT_4_7:     cal_tgt[1] = data;
         REG_TGT_8_11:    cal_tgt[2] = data;
         default:         cal_tgt[3] = data;
      endcase
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Driver: offers queued samples with random gaps.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.sample <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_values.push_back(calibrate(req_chan.sample));
            sent++;
         end
         if (req_chan.valid && !req_chan.ready) begin
            // keep offering the same item
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_samples.size() > 0 && !send_paused) begin
            req_chan.valid <= 1'b1;
            req_chan.sample <= pending_samples.pop_front();
            send_gap <= gap_len();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Monitor: random back-pressure and comparison of each value.
   int stall_cnt = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_values.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected value %0d", rsp_chan.value);
            end else begin
               logic [ValueW-1:0] want;
               want = expected_values.pop_front();
               checked++;
               if (rsp_chan.value !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("value mismatch: expected %0d actual %0d", want, rsp_chan.value);
               end
            end
         end
         if (rsp_hold_long) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_cnt <= gap_len();
         end
      end
   end

   // Waits until the clocked processes have settled after each edge and nothing is left.
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_samples.size() > 0 || req_chan.valid || expected_values.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [RegW-1:0] rising_bps();
      logic [RegW-1:0] w;
      int v;
      v = 0;
      for (int i = 0; i < 8; i++) begin
         v = v + $urandom_range(1, 30);
         w[i*8 +: 8] = v[7:0];
      end
      return w;
   endfunction

   function automatic logic [RegW-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Stimulus and table settings.
   initial begin
      int phase_items;
      logic [RegW-1:0] lo_bp;
      cal_count = RstPointCount;
      cal_bp[0] = RstBpLow;
      cal_bp[1] = RstBpHigh;
      cal_tgt[0] = RstTgt03;
      cal_tgt[1] = RstTgt47;
      cal_tgt[2] = RstTgt811;
      cal_tgt[3] = RstTgt1215;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset table, sample extremes and breakpoints 35, 128, 231 and 255 exactly.
      pending_samples.push_back(8'd0);
      pending_samples.push_back(8'd1);
      pending_samples.push_back(8'd35);
      pending_samples.push_back(8'd36);
      pending_samples.push_back(8'd128);
      pending_samples.push_back(8'd231);
      pending_samples.push_back(8'd254);
      pending_samples.push_back(8'd255);
      pending_samples.push_back(8'hAA);
      pending_samples.push_back(8'h55);
      wait_drained();

      // Directed: non-rising breakpoint, zero result, falling slope, counts 0 and 31.
      write_reg(REG_BP_LOW, 64'h00000000_80_40_50_00);
      write_reg(REG_TGT_0_3, 64'h0000_0000_0010_0000);
      write_reg(REG_POINT_COUNT, 64'd0);
      pending_samples.push_back(8'd0);
      pending_samples.push_back(8'd80);
      pending_samples.push_back(8'd81);
      wait_drained();
      write_reg(REG_POINT_COUNT, 64'd31);
      write_reg(REG_TGT_12_15, 64'hFFFF_1234_0000_0001);
      write_reg(REG_TGT_0_3, 64'h0000_0000_0000_FFFF);
      pending_samples.push_back(8'd0);
      pending_samples.push_back(8'd40);
      pending_samples.push_back(8'd70);
      pending_samples.push_back(8'd255);
      wait_drained();

      // Random phases over varied tables.
      for (int ph = 0; ph < 24; ph++) begin
         write_reg(REG_POINT_COUNT, RegW'((ph % 6 == 0) ? 5'd16 : (ph % 6 == 1) ? 5'd2 :
                   5'($urandom_range(0, 31))));
         lo_bp = rising_bps();
         write_reg(REG_BP_LOW, ($urandom_range(0, 3) == 0) ? rand64() : lo_bp);
         write_reg(REG_BP_HIGH, ($urandom_range(0, 3) == 0) ? rand64() :
                   (rising_bps() + {8{lo_bp[63:56]}}));
         for (int r = 0; r < 4; r++)
            write_reg(csr_index_type'(REG_TGT_0_3 + r),
                      (ph % 8 == 3) ? {64{1'b1}} : (ph % 8 == 5) ? 64'd0 : rand64());
         phase_items = 75;
         for (int k = 0; k < phase_items; k++)
            pending_samples.push_back(8'($urandom_range(0, 255)));
         if (ph == 4) begin
            // Long output stall while samples keep coming.
            rsp_hold_long = 1'b1;
            repeat (200) @(posedge clock);
            rsp_hold_long = 1'b0;
         end
         if (ph == 9) begin
            // Sender pause until all outstanding values return.
            repeat (20) @(posedge clock);
            send_paused = 1'b1;
            while (expected_values.size() > 0 || req_chan.valid) @(posedge clock);
            send_paused = 1'b0;
         end
         wait_drained();
      end

      $display("Sent %0d samples across 27 table settings; %0d values checked.", sent, checked);
      if (mismatches == 0 && expected_values.size() == 0) begin
         $display("piecewise_linear_calibration_tb passed");
      end else begin
         $display("piecewise_linear_calibration_tb failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("piecewise_linear_calibration_tb failed");
      $finish;
   end
endmodule
